/* rtl/sadr_pkg.sv */
`timescale 1ns / 1ps

package sadr_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int DUE_W     = 32;
    localparam int DELAY_W   = 16;
    localparam int PM_W      = SLOT_W + 1;
    localparam int FIFO_W    = SLOT_W + DUE_W;
    localparam int TBL_AW    = SLOT_W + 1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd500;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [0:0] REG_REUSE_DELAY = 1'd0;

    localparam logic PAGE_POS  = 1'b0;
    localparam logic PAGE_LIST = 1'b1;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b00000001,
        ST_IDLE   = 8'b00000010,
        ST_PICK   = 8'b00000100,
        ST_LOOK   = 8'b00001000,
        ST_APPEND = 8'b00010000,
        ST_MOVE   = 8'b00100000,
        ST_FIX    = 8'b01000000,
        ST_DONE   = 8'b10000000
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] pos;
    } pm_entry_t;

endpackage

/* rtl/slot_allocator_delayed_reuse_core.sv */
`timescale 1ns / 1ps
// Slot allocator with delayed reuse.
// Input channel s_*: one command item (allocate, add, release) with slot_id and cycle_now.
// Result channel m_*: exactly one result item per command, in command order.
// APB port: register 0 (address 0) holds reuse_delay, 16 bits, reset value 500.
// Allocate takes the head of the release FIFO once its due cycle is below cycle_now,
// else the next fresh slot, else reports failure; a granted slot is swap-removed from
// the dense active list. Add appends to it; release swap-removes from it and queues
// the slot with due = now + delay. State lives in two RAMs with a registered read: the
// release FIFO, and one table whose lower half is the position map and upper half the
// active list; a release that finds the FIFO full queues nothing. A known command steps
// through PICK (allocate only), LOOK, APPEND (add) or MOVE and FIX (swap), and DONE,
// skipping those it does not need; an unknown one goes straight to DONE. One command is
// in work at a time; the next is taken as soon as the sequencer returns to idle, even
// while the previous result still waits in the output register.
// After reset the position map is cleared one entry per cycle, all 1024 entries, during
// which s_tready stays low; APB writes are taken throughout.
// When the receiver stalls, the result is held in the output register and the
// sequencer waits before loading the following one.

module slot_allocator_delayed_reuse_core
    import sadr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // slot_id[9:0], cycle_now[41:10], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot_out[9:0], status[10], was_reused[11],
                                   // active_total[22:12], slots_in_use[33:23],
                                   // last_valid[34], last_slot[44:35], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t              state_reg, state_next;
    logic [DELAY_W-1:0]  delay_reg;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    ffill_reg, ffill_next;
    logic [CNT_W-1:0]    afill_reg, afill_next;
    logic [SLOT_W-1:0]   recent_reg, recent_next;
    logic                rvalid_reg, rvalid_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [SLOT_W-1:0]   target_reg, target_next;
    logic [DUE_W-1:0]    now_reg, now_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   moved_reg, moved_next;
    logic [SLOT_W-1:0]   grant_reg, grant_next;
    logic                fail_reg, fail_next;
    logic                reused_reg, reused_next;
    logic                mvalid_reg, mvalid_next;
    logic [47:0]         mdata_reg, mdata_next;

    logic [SLOT_W-1:0]   s_sid;
    logic [DUE_W-1:0]    s_now;
    logic                s_fire;
    logic                cfg_wr;

    logic                fifo_we;
    logic [FIFO_W-1:0]   fifo_wdata, fifo_rdata;
    logic [SLOT_W-1:0]   fifo_rslot;
    logic [DUE_W-1:0]    fifo_rdue;

    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr, tbl_raddr;
    pm_entry_t           tbl_wdata, tbl_rdata;
    logic [SLOT_W-1:0]   last_idx;

    logic                reuse_ok;

    assign s_sid  = s_tdata[SLOT_W-1:0];
    assign s_now  = s_tdata[SLOT_W+DUE_W-1:SLOT_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REUSE_DELAY);
    assign prdata = (paddr[2] == REG_REUSE_DELAY) ? {16'd0, delay_reg} : 32'd0;

    assign {fifo_rslot, fifo_rdue} = fifo_rdata;
    assign fifo_wdata = {s_sid, s_now + {16'd0, delay_reg}};
    assign fifo_we    = s_fire && (s_tuser == CMD_RELEASE) && !ffill_reg[CNT_W-1];
    assign reuse_ok   = (ffill_reg != '0) && (fifo_rdue < now_reg);

    assign last_idx  = afill_reg[SLOT_W-1:0] - 1'b1;
    assign tbl_raddr = (state_reg == ST_LOOK) ? {PAGE_LIST, last_idx} :
                       (state_reg == ST_PICK) ? {PAGE_POS, grant_next} :
                                                {PAGE_POS, s_sid};

    sadr_ram #(.WIDTH(FIFO_W), .DEPTH(MAX_SLOTS)) u_fifo (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (fifo_wdata),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

    sadr_ram #(.WIDTH(PM_W), .DEPTH(2 * MAX_SLOTS)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        fresh_next  = fresh_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ffill_next  = ffill_reg;
        afill_next  = afill_reg;
        recent_next = recent_reg;
        rvalid_next = rvalid_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        target_next = target_reg;
        now_next    = now_reg;
        pos_next    = pos_reg;
        moved_next  = moved_reg;
        grant_next  = grant_reg;
        fail_next   = fail_reg;
        reused_next = reused_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = {PAGE_POS, target_reg};
        tbl_wdata   = '0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = {PAGE_POS, clr_reg};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(MAX_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = s_tuser;
                    target_next = s_sid;
                    now_next    = s_now;
                    grant_next  = '0;
                    fail_next   = 1'b0;
                    reused_next = 1'b0;
                    case (s_tuser)
                        CMD_ALLOC: state_next = ST_PICK;
                        CMD_ADD: begin
                            recent_next = s_sid;
                            rvalid_next = 1'b1;
                            state_next  = ST_LOOK;
                        end
                        CMD_RELEASE: begin
                            if (rvalid_reg && recent_reg == s_sid) begin
                                rvalid_next = 1'b0;
                            end
                            if (fifo_we) begin
                                tail_next  = tail_reg + 1'b1;
                                ffill_next = ffill_reg + 1'b1;
                            end
                            state_next = ST_LOOK;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_PICK: begin
                if (reuse_ok) begin
                    grant_next  = fifo_rslot;
                    reused_next = 1'b1;
                    head_next   = head_reg + 1'b1;
                    ffill_next  = ffill_reg - 1'b1;
                    target_next = fifo_rslot;
                    state_next  = ST_LOOK;
                end else if (!fresh_reg[CNT_W-1]) begin
                    grant_next  = fresh_reg[SLOT_W-1:0];
                    fresh_next  = fresh_reg + 1'b1;
                    target_next = fresh_reg[SLOT_W-1:0];
                    state_next  = ST_LOOK;
                end else begin
                    fail_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_LOOK: begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_ADD) begin
                    if (!tbl_rdata.valid && !afill_reg[CNT_W-1]) begin
                        tbl_we          = 1'b1;
                        tbl_wdata.valid = 1'b1;
                        tbl_wdata.pos   = afill_reg[SLOT_W-1:0];
                        state_next      = ST_APPEND;
                    end
                end else if (tbl_rdata.valid) begin
                    tbl_we = 1'b1;
                    if ({1'b0, tbl_rdata.pos} < afill_reg) begin
                        pos_next   = tbl_rdata.pos;
                        state_next = ST_MOVE;
                    end
                end
            end
            ST_APPEND: begin
                tbl_we        = 1'b1;
                tbl_waddr     = {PAGE_LIST, afill_reg[SLOT_W-1:0]};
                tbl_wdata.pos = target_reg;
                afill_next    = afill_reg + 1'b1;
                state_next    = ST_DONE;
            end
            ST_MOVE: begin
                tbl_we        = 1'b1;
                tbl_waddr     = {PAGE_LIST, pos_reg};
                tbl_wdata.pos = tbl_rdata.pos;
                moved_next    = tbl_rdata.pos;
                afill_next    = afill_reg - 1'b1;
                if (tbl_rdata.pos != target_reg) begin
                    state_next = ST_FIX;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FIX: begin
                tbl_we          = 1'b1;
                tbl_waddr       = {PAGE_POS, moved_reg};
                tbl_wdata.valid = 1'b1;
                tbl_wdata.pos   = pos_reg;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {3'd0,
                                   rvalid_reg ? recent_reg : {SLOT_W{1'b0}},
                                   rvalid_reg, fresh_reg, afill_reg,
                                   reused_reg, fail_reg, grant_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            delay_reg  <= DELAY_RESET;
            fresh_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            ffill_reg  <= '0;
            afill_reg  <= '0;
            recent_reg <= '0;
            rvalid_reg <= 1'b0;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_wr) begin
                delay_reg <= pwdata[DELAY_W-1:0];
            end
            fresh_reg  <= fresh_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            ffill_reg  <= ffill_next;
            afill_reg  <= afill_next;
            recent_reg <= recent_next;
            rvalid_reg <= rvalid_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        target_reg <= target_next;
        now_reg    <= now_next;
        pos_reg    <= pos_next;
        moved_reg  <= moved_next;
        grant_reg  <= grant_next;
        fail_reg   <= fail_next;
        reused_reg <= reused_next;
        mdata_reg  <= mdata_next;
    end

`ifndef NO_ASSERTIONS
    a_afill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        afill_reg <= CNT_W'(MAX_SLOTS))
        else $error("active list fill beyond capacity");

    a_fifo_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        ffill_reg[SLOT_W-1:0] == SLOT_W'(tail_reg - head_reg))
        else $error("release queue pointers disagree with fill count");

    a_move_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOVE |=> afill_reg == $past(afill_reg) - 1'b1)
        else $error("swap-remove did not shrink the active list");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && !mvalid_reg |=> mvalid_reg && state_reg == ST_IDLE)
        else $error("finished item not loaded into output register");
`endif

endmodule

/* rtl/sadr_ram.sv */
`timescale 1ns / 1ps

module sadr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sadr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] DELAY_ADDR = {REG_REUSE_DELAY, 2'b00};
    localparam int         EXP_DEPTH  = 16;
    localparam int         GRANT_KEEP = 32;

    typedef struct {
        logic [9:0]  slot_out;
        logic        status;
        logic        was_reused;
        logic [10:0] active_total;
        logic [10:0] slots_in_use;
        logic        last_valid;
        logic [9:0]  last_slot;
    } slot_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // slot_id[9:0], cycle_now[41:10], zero pad
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // slot_out[9:0], status[10], was_reused[11],
                            // active_total[22:12], slots_in_use[33:23],
                            // last_valid[34], last_slot[44:35], zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slot_allocator_delayed_reuse_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // allocator shadow state
    logic [15:0] delay_shadow = DELAY_RESET;
    int          fresh_next = 0;
    logic [9:0]  relq_slot [MAX_SLOTS];
    logic [31:0] relq_due [MAX_SLOTS];
    logic [9:0]  relq_head = '0;
    logic [9:0]  relq_tail = '0;
    int          relq_count = 0;
    logic [9:0]  dense_list [MAX_SLOTS];
    int          dense_pos [MAX_SLOTS];
    bit          in_dense [MAX_SLOTS];
    int          dense_count = 0;
    logic [9:0]  newest_slot = '0;
    logic        newest_valid = 1'b0;

    slot_result_t exp_ring [EXP_DEPTH];
    int           exp_wr = 0;
    int           exp_rd = 0;
    logic [9:0]   granted_ring [GRANT_KEEP];
    int           granted_count = 0;
    int           granted_wr = 0;
    logic [31:0]  game_now = '0;
    int           fail_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    int           hold_cycles = 0;
    int           stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void drop_from_dense(logic [9:0] s);
        int         p;
        logic [9:0] tail_slot;
        if (!in_dense[s]) return;
        in_dense[s] = 1'b0;
        p = dense_pos[s];
        if (dense_count == 0 || p >= dense_count) return;
        tail_slot = dense_list[dense_count - 1];
        dense_list[p] = tail_slot;
        dense_pos[tail_slot] = p;
        dense_count--;
    endfunction

    function automatic slot_result_t predict_slot_step(logic [1:0] cmd, logic [9:0] sid,
                                                       logic [31:0] cyc);
        slot_result_t r;
        r = '{default: '0};
        if (cmd == CMD_ALLOC) begin
            if (relq_count > 0 && relq_due[relq_head] < cyc) begin
                r.slot_out   = relq_slot[relq_head];
                r.was_reused = 1'b1;
                relq_head    = relq_head + 1'b1;
                relq_count--;
                drop_from_dense(r.slot_out);
            end else if (fresh_next < MAX_SLOTS) begin
                r.slot_out = 10'(fresh_next);
                fresh_next++;
                drop_from_dense(r.slot_out);
            end else begin
                r.status = 1'b1;
            end
        end else if (cmd == CMD_ADD) begin
            newest_slot  = sid;
            newest_valid = 1'b1;
            if (!in_dense[sid] && dense_count < MAX_SLOTS) begin
                dense_pos[sid] = dense_count;
                in_dense[sid]  = 1'b1;
                dense_list[dense_count] = sid;
                dense_count++;
            end
        end else if (cmd == CMD_RELEASE) begin
            if (newest_valid && newest_slot == sid)
                newest_valid = 1'b0;
            drop_from_dense(sid);
            if (relq_count < MAX_SLOTS) begin
                relq_slot[relq_tail] = sid;
                relq_due[relq_tail]  = cyc + {16'd0, delay_shadow};
                relq_tail = relq_tail + 1'b1;
                relq_count++;
            end
        end
        r.active_total = 11'(dense_count);
        r.slots_in_use = 11'(fresh_next);
        r.last_valid   = newest_valid;
        r.last_slot    = newest_valid ? newest_slot : '0;
        return r;
    endfunction

    function automatic logic [9:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && granted_count > 0)
            return granted_ring[$urandom_range(0, granted_count - 1)];
        if (r < 70 && dense_count > 0)
            return dense_list[$urandom_range(0, dense_count - 1)];
        return 10'($urandom());
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [9:0] sid, input logic [31:0] cyc);
        int           gap;
        slot_result_t r;
        gap = tx_idle_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, cyc, sid};
        do @(posedge aclk); while (!s_tready);
        r = predict_slot_step(cmd, sid, cyc);
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
        if (cmd == CMD_ALLOC && !r.status) begin
            granted_ring[granted_wr] = r.slot_out;
            granted_wr = (granted_wr + 1) % GRANT_KEEP;
            if (granted_count < GRANT_KEEP) granted_count++;
        end
    endtask

    task automatic random_item();
        int         r;
        logic [1:0] cmd;
        logic [31:0] cyc;
        r = $urandom_range(0, 99);
        if (r < 36) cmd = CMD_ALLOC;
        else if (r < 66) cmd = CMD_ADD;
        else if (r < 96) cmd = CMD_RELEASE;
        else cmd = CMD_UNUSED;
        game_now += $urandom_range(0, 30);
        cyc = ($urandom_range(0, 99) < 5) ? $urandom() : game_now;
        send_item(cmd, pick_slot(), cyc);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
    endtask

    task automatic write_delay(input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DELAY_ADDR;
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        delay_shadow = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        compare_field("reuse_delay readback", value, prdata[15:0]);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed();
        write_delay(16'd0);
        send_item(CMD_ALLOC, 10'h3FF, 32'd0);
        send_item(CMD_ALLOC, 10'h000, 32'd0);
        send_item(CMD_ADD, 10'd0, 32'd0);
        send_item(CMD_ADD, 10'd1, 32'd0);
        send_item(CMD_ADD, 10'd1, 32'd0);
        send_item(CMD_ADD, 10'd1023, 32'd0);
        send_item(CMD_RELEASE, 10'd1023, 32'd10);
        send_item(CMD_ALLOC, 10'd0, 32'd10);
        send_item(CMD_ALLOC, 10'd0, 32'd11);
        send_item(CMD_RELEASE, 10'd7, 32'd20);
        send_item(CMD_ADD, 10'd7, 32'd20);
        send_item(CMD_ALLOC, 10'd0, 32'd21);
        send_item(CMD_UNUSED, 10'd1023, 32'hFFFF_FFFF);
        send_item(CMD_RELEASE, 10'd0, 32'hFFFF_FFFE);
        send_item(CMD_ALLOC, 10'd0, 32'hFFFF_FFFE);
        send_item(CMD_ALLOC, 10'd0, 32'hFFFF_FFFF);
        wait_results_drained();
        write_delay(16'hFFFF);
        send_item(CMD_ADD, 10'h2AA, 32'h5555_5555);
        send_item(CMD_RELEASE, 10'd1, 32'hFFFF_FF00);
        send_item(CMD_ALLOC, 10'h155, 32'h0000_FEFF);
        send_item(CMD_ALLOC, 10'd0, 32'h0000_FF00);
        send_item(CMD_RELEASE, 10'h2AA, 32'hAAAA_AAAA);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        write_delay(16'd40);
        tx_idle_on  = 1'b0;
        hold_cycles = 300;
        repeat (40) random_item();
        wait_results_drained();
    endtask

    task automatic test_random(input int count, input logic [15:0] delay, input logic [31:0] start);
        write_delay(delay);
        game_now = start;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            random_item();
        end
        wait_results_drained();
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        slot_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_rd == exp_wr) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: %h", m_tdata);
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                compare_field("slot_out", want.slot_out, m_tdata[9:0]);
                compare_field("status", want.status, m_tdata[10]);
                compare_field("was_reused", want.was_reused, m_tdata[11]);
                compare_field("active_total", want.active_total, m_tdata[22:12]);
                compare_field("slots_in_use", want.slots_in_use, m_tdata[33:23]);
                compare_field("last_valid", want.last_valid, m_tdata[34]);
                compare_field("last_slot", want.last_slot, m_tdata[44:35]);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(230, 16'($urandom_range(1, 100)), 32'($urandom_range(0, 1000)));
        test_random(230, 16'hFFFF, 32'hFFFF_F000);
        test_random(230, DELAY_RESET, $urandom());
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && exp_wr == exp_rd)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
